[src/scds_pkg.sv]
// Shared types and constants for the spi clock divisor search block.
// Depends on nothing; every other file in src imports it.
`default_nettype none

package scds_pkg;

    // field widths of the items
    localparam int CLOCK_W     = 32;
    localparam int PRESCALE_W  = 3;
    localparam int DIVIDER_W   = 4;

    // the divider retires one 4-bit digit of the quotient per cycle
    localparam int DIGIT_BITS  = 4;
    localparam int DIGITS      = CLOCK_W / DIGIT_BITS;
    localparam int DIGIT_CNT_W = $clog2(DIGITS);

    // shortfall value that nothing has beaten yet
    localparam logic [CLOCK_W-1:0] GAP_START = {CLOCK_W{1'b1}};

    typedef struct packed {
        logic [CLOCK_W-1:0] clock_hz;
        logic [CLOCK_W-1:0] target_hz;
    } scds_in_t;

    typedef struct packed {
        logic [PRESCALE_W-1:0] prescale_sel;
        logic [DIVIDER_W-1:0]  divider_sel;
    } scds_out_t;

    // status of the shared divider as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } scds_div_stat_t;

endpackage

`default_nettype wire

[src/scds_divider.sv]
// Iterative divider of a 32-bit value by a small divisor, four quotient bits per cycle.
// Depends on scds_pkg for widths and the status struct.
`default_nettype none

module scds_divider
    import scds_pkg::*;
#(
    parameter int DIVISOR_W = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 launch,
    input  wire logic [CLOCK_W-1:0]   dividend,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output scds_div_stat_t            stat,
    output logic [CLOCK_W-1:0]        quotient
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIGIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CLOCK_W-1:0]     acc_reg, acc_next;
    logic [DIVISOR_W-1:0]   rem_reg, rem_next;
    logic [DIVISOR_W-1:0]   div_reg, div_next;
    logic [CLOCK_W-1:0]     step_acc;
    logic [DIVISOR_W-1:0]   step_rem;

    // one radix-16 digit: four restoring steps on the narrow remainder
    always_comb
    begin
        logic [DIVISOR_W:0] trial;
        step_acc = acc_reg;
        step_rem = rem_reg;
        for (int k = 0; k < DIGIT_BITS; k++)
        begin
            trial    = {step_rem, step_acc[CLOCK_W-1]};
            step_acc = {step_acc[CLOCK_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                step_rem    = DIVISOR_W'(trial - {1'b0, div_reg});
                step_acc[0] = 1'b1;
            end
            else
            begin
                step_rem = DIVISOR_W'(trial);
            end
        end
    end

    // digit sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (launch)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            acc_next = step_acc;
            rem_next = step_rem;
            cnt_next = cnt_reg + DIGIT_CNT_W'(1);
            if (cnt_reg == DIGIT_CNT_W'(DIGITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = acc_reg;

endmodule

`default_nettype wire

[src/spi_clock_divisor_search.sv]
// Top level: sequencer that walks prescaler and divider codes for the best spi bit rate.
// Depends on scds_pkg and scds_divider.
//
//  channel   signals                      direction  taken when
//  input     start, busy, request         in         start high and busy low
//  result    done, result                 out        done high (one cycle)
//
// For each prescaler code p the sequencer launches the shared divider (clock_hz / (p+1),
// eight 4-bit digits, then its done flag), waits on it and then shifts that quotient right
// one place for each divider code up to MAX_DIVIDER_CODE to score that code. The search
// ends early once an exact match is found.
// done rises in the cycle after the last compare, with busy already low.
// Reset is asynchronous and active low; results cannot be held off by the receiver.
`default_nettype none

module spi_clock_divisor_search
    import scds_pkg::*;
#(
    parameter int MAX_PRESCALE_CODE = 7,
    parameter int MAX_DIVIDER_CODE  = 8
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire scds_in_t request,
    output logic          done,
    output scds_out_t     result
);

    localparam int PCW = $clog2(MAX_PRESCALE_CODE + 1);
    localparam int DCW = $clog2(MAX_DIVIDER_CODE + 1);
    localparam int DVW = $clog2(MAX_PRESCALE_CODE + 2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_DIVIDE,
        ST_SCAN
    } state_t;

    state_t               state_reg, state_next;
    logic                 done_reg, done_next;
    scds_out_t            result_reg, result_next;
    logic [CLOCK_W-1:0]   clock_reg, clock_next;
    logic [CLOCK_W-1:0]   target_reg, target_next;
    logic [PCW-1:0]       p_reg, p_next;
    logic [DCW-1:0]       d_reg, d_next;
    logic [CLOCK_W-1:0]   shf_reg, shf_next;
    logic [CLOCK_W-1:0]   gap_reg, gap_next;
    logic [PCW-1:0]       best_p_reg, best_p_next;
    logic [DCW-1:0]       best_d_reg, best_d_next;

    scds_div_stat_t       div_stat;
    logic [CLOCK_W-1:0]   div_quot;
    logic [DVW-1:0]       div_divisor;

    assign div_divisor = DVW'(p_reg) + DVW'(1);

    scds_divider #(
        .DIVISOR_W (DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .launch   (state_reg == ST_LAUNCH),
        .dividend (clock_reg),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // search sequencer and candidate scoring
    always_comb
    begin
        logic [CLOCK_W-1:0] gap;
        logic               take;
        logic               stop;
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        clock_next  = clock_reg;
        target_next = target_reg;
        p_next      = p_reg;
        d_next      = d_reg;
        shf_next    = shf_reg;
        gap_next    = gap_reg;
        best_p_next = best_p_reg;
        best_d_next = best_d_reg;
        gap         = target_reg - shf_reg;
        take        = (target_reg >= shf_reg) && (gap < gap_reg);
        stop        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    clock_next  = request.clock_hz;
                    target_next = request.target_hz;
                    p_next      = '0;
                    gap_next    = GAP_START;
                    best_p_next = PCW'(MAX_PRESCALE_CODE);
                    best_d_next = DCW'(MAX_DIVIDER_CODE);
                    state_next  = ST_LAUNCH;
                end
            end
            ST_LAUNCH:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                // rate for d = 0 is the quotient halved
                if (div_stat.done)
                begin
                    shf_next   = div_quot >> 1;
                    d_next     = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (take)
                begin
                    gap_next    = gap;
                    best_p_next = p_reg;
                    best_d_next = d_reg;
                end
                shf_next = shf_reg >> 1;
                d_next   = d_reg + DCW'(1);
                // exact match ends the search early
                stop = take && (gap == '0);
                if (stop || (d_reg == DCW'(MAX_DIVIDER_CODE)))
                begin
                    if (stop || (p_reg == PCW'(MAX_PRESCALE_CODE)))
                    begin
                        done_next                = 1'b1;
                        result_next.prescale_sel = PRESCALE_W'(best_p_next);
                        result_next.divider_sel  = DIVIDER_W'(best_d_next);
                        state_next               = ST_IDLE;
                    end
                    else
                    begin
                        p_next     = p_reg + PCW'(1);
                        state_next = ST_LAUNCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // working values, no reset needed
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        clock_reg  <= clock_next;
        target_reg <= target_next;
        p_reg      <= p_next;
        d_reg      <= d_next;
        shf_reg    <= shf_next;
        gap_reg    <= gap_next;
        best_p_reg <= best_p_next;
        best_d_reg <= best_d_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[src/scds_checker.sv]
// Port-level checks on the divisor search block, bound to the top level.
// Depends on scds_pkg and spi_clock_divisor_search.
`default_nettype none

module scds_checker
    import scds_pkg::*;
#(
    parameter int MAX_DIVIDER_CODE = 8
)
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      start,
    input wire logic      busy,
    input wire logic      done,
    input wire scds_out_t result
);

    // an accepted item makes the block busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // busy only ever rises after an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose with no item accepted");

    // the result strobe comes once the search has finished
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside end of search");

    // no divider code beyond the last one searched
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.divider_sel <= DIVIDER_W'(MAX_DIVIDER_CODE)))
        else $error("divider code out of range");

endmodule

bind spi_clock_divisor_search scds_checker #(
    .MAX_DIVIDER_CODE (MAX_DIVIDER_CODE)
) u_scds_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

`default_nettype wire

[bench/spi_divisor_checker.sv]
`timescale 1ns / 100ps
// Checker for the spi clock divisor search: works out the prescaler and divider codes
// for every accepted item and compares them with each result strobe, oldest first.
// Depends on scds_pkg; instantiated beside the block by spi_clock_divisor_search_tb.

module spi_divisor_checker
    import scds_pkg::*;
#(
    parameter int MAX_PRESCALE_CODE = 7,
    parameter int MAX_DIVIDER_CODE  = 8
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  scds_in_t  request,
    input  wire logic done,
    input  scds_out_t result,
    output int        fail_count,
    output int        pending
);

    localparam int PRINT_LIMIT = 100;

    scds_out_t expected_pairs[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // one line per mismatch, quiet after the first hundred but still counted
    task automatic flag_error(input string msg);
        if (fail_count < PRINT_LIMIT)
        begin
            $display("[%0t] divisor check: %s", $time, msg);
        end
        fail_count++;
    endtask

    // pair with the smallest shortfall at or below the target; a tie keeps the earlier pair
    function automatic scds_out_t best_divisor_pair(input logic [CLOCK_W-1:0] clock_hz,
                                                    input logic [CLOCK_W-1:0] target_hz);
        logic [CLOCK_W-1:0] best_gap;
        logic [CLOCK_W-1:0] rate;
        logic [CLOCK_W-1:0] gap;
        logic [63:0]        divisor;
        scds_out_t          pick;
        best_gap          = GAP_START;
        pick.prescale_sel = PRESCALE_W'(MAX_PRESCALE_CODE);
        pick.divider_sel  = DIVIDER_W'(MAX_DIVIDER_CODE);
        for (int p = 0; p <= MAX_PRESCALE_CODE; p++)
        begin
            for (int d = 0; d <= MAX_DIVIDER_CODE; d++)
            begin
                divisor = 64'(p + 1) << (d + 1);
                rate    = CLOCK_W'({32'd0, clock_hz} / divisor);
                if (target_hz >= rate)
                begin
                    gap = target_hz - rate;
                    if (gap < best_gap)
                    begin
                        best_gap          = gap;
                        pick.prescale_sel = PRESCALE_W'(p);
                        pick.divider_sel  = DIVIDER_W'(d);
                    end
                end
            end
        end
        return pick;
    endfunction

    // results first: a strobe in the same cycle as an accept belongs to an older item
    always @(posedge clk or negedge rst_n)
    begin
        scds_out_t want;
        if (!rst_n)
        begin
            expected_pairs.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_pairs.size() == 0)
                begin
                    flag_error($sformatf("result p=%0d d=%0d with no item outstanding",
                                         result.prescale_sel, result.divider_sel));
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (result.prescale_sel !== want.prescale_sel)
                    begin
                        flag_error($sformatf("prescale_sel got %0d want %0d",
                                             result.prescale_sel, want.prescale_sel));
                    end
                    if (result.divider_sel !== want.divider_sel)
                    begin
                        flag_error($sformatf("divider_sel got %0d want %0d",
                                             result.divider_sel, want.divider_sel));
                    end
                end
            end
            if (start && !busy)
            begin
                expected_pairs.push_back(best_divisor_pair(request.clock_hz,
                                                           request.target_hz));
            end
            pending = expected_pairs.size();
        end
    end

endmodule

[bench/spi_clock_divisor_search_tb.sv]
`timescale 1ns / 100ps
// Testbench top for spi_clock_divisor_search: sends directed clock/target items, then random
// ones in bursts, and gives the verdict. Depends on scds_pkg, the block and spi_divisor_checker.

module spi_clock_divisor_search_tb
    import scds_pkg::*;
();

    localparam int MAX_PRESCALE_CODE = 7;
    localparam int MAX_DIVIDER_CODE  = 8;
    localparam int RANDOM_ITEMS      = 750;
    localparam int CYCLE_LIMIT       = 800000;
    localparam int SETTLE_CYCLES     = 200;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    logic      busy;
    scds_in_t  request;
    logic      done;
    scds_out_t result;
    int        fail_count;
    int        pending;
    int        cycles = 0;

    // extremes, exact matches, ties, no qualifying pair, zero clock, all-ones target
    logic [63:0] directed_items [21] = '{
        {32'd0,          32'd0},
        {32'd0,          32'hFFFF_FFFF},
        {32'd0,          32'd5},
        {32'd1,          32'd0},
        {32'd1,          32'hFFFF_FFFF},
        {32'hFFFF_FFFF,  32'd0},
        {32'hFFFF_FFFF,  32'hFFFF_FFFF},
        {32'hFFFF_FFFF,  32'hFFFF_FFFE},
        {32'hFFFF_FFFF,  32'h7FFF_FFFF},
        {32'd48000000,   32'd3000000},
        {32'd48000000,   32'd2999999},
        {32'd48000000,   32'd3000001},
        {32'd24000000,   32'd3000000},
        {32'd12000000,   32'd3000000},
        {32'd2,          32'd1},
        {32'd4096,       32'd0},
        {32'd4095,       32'd0},
        {32'd24000000,   32'd1},
        {32'd100000000,  32'd100000000},
        {32'd80000000,   32'd999999},
        {32'h8000_0000,  32'h0000_0001}
    };

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    spi_clock_divisor_search #(
        .MAX_PRESCALE_CODE (MAX_PRESCALE_CODE),
        .MAX_DIVIDER_CODE  (MAX_DIVIDER_CODE)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    spi_divisor_checker #(
        .MAX_PRESCALE_CODE (MAX_PRESCALE_CODE),
        .MAX_DIVIDER_CODE  (MAX_DIVIDER_CODE)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic drive_item(input scds_in_t item);
        start   <= 1'b1;
        request <= item;
        while (busy)
        begin
            @(negedge clk);
        end
        @(negedge clk);
    endtask

    // sender idle with noise on the request lines
    task automatic pause_sender(input int unsigned idle_cycles);
        start <= 1'b0;
        repeat (idle_cycles)
        begin
            request <= {$urandom, $urandom};
            @(negedge clk);
        end
    endtask

    // hold off until every outstanding result has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // mostly targets near a reachable rate on realistic or raw clocks, plus raw and edge values
    function automatic scds_in_t random_item();
        scds_in_t    item;
        logic [31:0] rate;
        int unsigned pick;
        int unsigned p;
        int unsigned d;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            if ($urandom_range(0, 3) == 0)
                item.clock_hz = $urandom;
            else
                item.clock_hz = $urandom_range(1000000, 250000000);
            p    = $urandom_range(0, MAX_PRESCALE_CODE);
            d    = $urandom_range(0, MAX_DIVIDER_CODE);
            rate = item.clock_hz / ((p + 1) << (d + 1));
            case ($urandom_range(0, 3))
                0:       item.target_hz = rate;
                1:       item.target_hz = rate + $urandom_range(1, 5);
                2:       item.target_hz = rate - 1;
                default: item.target_hz = rate + $urandom_range(0, rate);
            endcase
        end
        else if (pick < 85)
        begin
            item.clock_hz  = $urandom;
            item.target_hz = $urandom;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       item.clock_hz = 32'd0;
                1:       item.clock_hz = 32'd1;
                2:       item.clock_hz = 32'hFFFF_FFFF;
                default: item.clock_hz = $urandom_range(0, 8191);
            endcase
            case ($urandom_range(0, 3))
                0:       item.target_hz = 32'd0;
                1:       item.target_hz = 32'hFFFF_FFFF;
                2:       item.target_hz = 32'hFFFF_FFFE;
                default: item.target_hz = $urandom_range(0, 4096);
            endcase
        end
        return item;
    endfunction

    // reset, directed items, random bursts, then drain and verdict
    initial
    begin
        int unsigned sent;
        int unsigned burst;
        bit          mid_drained;
        sent        = 0;
        mid_drained = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_items[i])
        begin
            drive_item(scds_in_t'(directed_items[i]));
            if ($urandom_range(0, 2) == 0)
                pause_sender($urandom_range(1, 6));
        end
        wait_drained();

        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                drive_item(random_item());
                sent++;
            end
            // one full hold-off halfway, otherwise gaps of random length or none
            if (!mid_drained && sent >= RANDOM_ITEMS / 2)
            begin
                wait_drained();
                mid_drained = 1'b1;
            end
            else if ($urandom_range(0, 2) != 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    pause_sender($urandom_range(1, 160));
                else
                    pause_sender($urandom_range(1, 20));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
